/* rtl/core/shell_word_tokenizer_core_assert.svh */
// Assertion macros shared by the tokenizer checker.
`ifndef SHELL_WORD_TOKENIZER_CORE_ASSERT_SVH
`define SHELL_WORD_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define SWT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define SWT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/swt_pkg.sv */
// Shared types, constants and character class functions of the word tokenizer.
package swt_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POSIX_MODE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPLIT_WS_ONLY    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMMENTS_ENABLED = 2'd2;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // One result item
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       token_end;
        logic       text_done;
        logic       last_of_item;
    } t_result;

    // One queue entry: the one or two results of an input item
    typedef struct packed {
        logic    two;
        t_result res0;
        t_result res1;
    } t_entry;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NL);
    endfunction

    function automatic logic is_wordch(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDER);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_SQUOTE) || (c == CH_DQUOTE);
    endfunction

    function automatic t_result mk_result(input logic [7:0] c, input logic cv,
                                          input logic te, input logic td);
        t_result r;
        r.out_char     = cv ? c : 8'h00;
        r.char_valid   = cv;
        r.token_end    = te;
        r.text_done    = td;
        r.last_of_item = 1'b0;
        return r;
    endfunction

endpackage

/* rtl/core/swt_front.sv */
// Front end: accepts bytes, holds the configuration and runs the lexer state machine.
module swt_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_ch,
    input  logic                           i_end_of_text,
    input  logic                           i_cfg_we,
    input  logic [swt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [swt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                           i_q_full,
    output logic                           o_push,
    output swt_pkg::t_entry                o_push_entry
);

    localparam logic [2:0] ST_SPACE   = 3'd0;
    localparam logic [2:0] ST_WORD    = 3'd1;
    localparam logic [2:0] ST_SQUOTE  = 3'd2;
    localparam logic [2:0] ST_DQUOTE  = 3'd3;
    localparam logic [2:0] ST_ESCAPE  = 3'd4;
    localparam logic [2:0] ST_COMMENT = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    logic r_posix, r_split_ws, r_comments;
    logic [2:0] r_st, n_st;
    logic [2:0] r_esc, n_esc;
    logic r_ciw, n_ciw;
    logic r_sq, n_sq;
    logic r_ne, n_ne;

    logic accept;
    logic eot;
    logic px;
    logic hash_on;
    logic [1:0] cnt;
    swt_pkg::t_result res [2];

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign eot     = i_end_of_text || (i_ch == swt_pkg::CH_NUL);
    assign px      = r_posix;
    assign hash_on = r_comments && (i_ch == swt_pkg::CH_HASH);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_posix    <= 1'b0;
            r_split_ws <= 1'b0;
            r_comments <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == swt_pkg::CFG_POSIX_MODE)       r_posix    <= i_cfg_data[0];
            if (i_cfg_index == swt_pkg::CFG_SPLIT_WS_ONLY)    r_split_ws <= i_cfg_data[0];
            if (i_cfg_index == swt_pkg::CFG_COMMENTS_ENABLED) r_comments <= i_cfg_data[0];
        end
    end

    // Lexer step: next state and the results of this byte, in order
    always_comb begin
        n_st   = r_st;
        n_esc  = r_esc;
        n_ciw  = r_ciw;
        n_sq   = r_sq;
        n_ne   = r_ne;
        cnt    = 2'd0;
        res[0] = swt_pkg::mk_result(8'h00, 1'b0, 1'b0, 1'b0);
        res[1] = swt_pkg::mk_result(8'h00, 1'b0, 1'b0, 1'b0);
        if (r_st >= ST_DONE) begin
            n_st = ST_DONE;
        end else if (eot) begin
            // flush the pending token, then mark the end of text
            if ((r_st == ST_SQUOTE) || (r_st == ST_DQUOTE)) n_sq = 1'b1;
            if (n_ne || (px && n_sq)) begin
                res[cnt[0]] = swt_pkg::mk_result(8'h00, 1'b0, 1'b1, 1'b0);
                cnt = cnt + 2'd1;
            end
            res[cnt[0]] = swt_pkg::mk_result(8'h00, 1'b0, 1'b0, 1'b1);
            cnt  = cnt + 2'd1;
            n_st = ST_DONE;
            n_ne = 1'b0;
            n_sq = 1'b0;
        end else begin
            case (r_st)
                ST_SPACE: begin
                    if (swt_pkg::is_space(i_ch)) begin
                        if (n_ne || (px && n_sq)) begin
                            res[cnt[0]] = swt_pkg::mk_result(8'h00, 1'b0, 1'b1, 1'b0);
                            cnt  = cnt + 2'd1;
                            n_ne = 1'b0;
                            n_sq = 1'b0;
                        end
                    end else if (hash_on) begin
                        n_ciw = 1'b0;
                        n_st  = ST_COMMENT;
                    end else if (px && (i_ch == swt_pkg::CH_BSLASH)) begin
                        n_esc = ST_WORD;
                        n_st  = ST_ESCAPE;
                    end else if (swt_pkg::is_wordch(i_ch)) begin
                        res[cnt[0]] = swt_pkg::mk_result(i_ch, 1'b1, 1'b0, 1'b0);
                        cnt  = cnt + 2'd1;
                        n_ne = 1'b1;
                        n_st = ST_WORD;
                    end else if (swt_pkg::is_quote(i_ch)) begin
                        if (!px) begin
                            res[cnt[0]] = swt_pkg::mk_result(i_ch, 1'b1, 1'b0, 1'b0);
                            cnt  = cnt + 2'd1;
                            n_ne = 1'b1;
                        end
                        n_st = (i_ch == swt_pkg::CH_SQUOTE) ? ST_SQUOTE : ST_DQUOTE;
                    end else if (r_split_ws) begin
                        res[cnt[0]] = swt_pkg::mk_result(i_ch, 1'b1, 1'b0, 1'b0);
                        cnt  = cnt + 2'd1;
                        n_ne = 1'b1;
                        n_st = ST_WORD;
                    end else begin
                        // punctuation forms a token of its own
                        res[cnt[0]] = swt_pkg::mk_result(i_ch, 1'b1, 1'b1, 1'b0);
                        cnt  = cnt + 2'd1;
                        n_ne = 1'b0;
                        n_sq = 1'b0;
                    end
                end
                ST_SQUOTE, ST_DQUOTE: begin
                    n_sq = 1'b1;
                    if (i_ch == ((r_st == ST_SQUOTE) ? swt_pkg::CH_SQUOTE
                                                     : swt_pkg::CH_DQUOTE)) begin
                        if (!px) begin
                            // classic closing quote: keep it and end the token
                            res[0] = swt_pkg::mk_result(i_ch, 1'b1, 1'b0, 1'b0);
                            res[1] = swt_pkg::mk_result(8'h00, 1'b0, 1'b1, 1'b0);
                            cnt  = 2'd2;
                            n_st = ST_SPACE;
                            n_ne = 1'b0;
                            n_sq = 1'b0;
                        end else begin
                            n_st = ST_WORD;
                        end
                    end else if (px && (i_ch == swt_pkg::CH_BSLASH) &&
                                 (r_st == ST_DQUOTE)) begin
                        n_esc = ST_DQUOTE;
                        n_st  = ST_ESCAPE;
                    end else begin
                        res[cnt[0]] = swt_pkg::mk_result(i_ch, 1'b1, 1'b0, 1'b0);
                        cnt  = cnt + 2'd1;
                        n_ne = 1'b1;
                    end
                end
                ST_ESCAPE: begin
                    // inside double quotes only quote and backslash drop the escape
                    if ((r_esc == ST_DQUOTE) && (i_ch != swt_pkg::CH_BSLASH) &&
                        (i_ch != swt_pkg::CH_DQUOTE)) begin
                        res[cnt[0]] = swt_pkg::mk_result(swt_pkg::CH_BSLASH, 1'b1, 1'b0,
                                                         1'b0);
                        cnt = cnt + 2'd1;
                    end
                    res[cnt[0]] = swt_pkg::mk_result(i_ch, 1'b1, 1'b0, 1'b0);
                    cnt  = cnt + 2'd1;
                    n_ne = 1'b1;
                    n_st = (r_esc == ST_DQUOTE) ? ST_DQUOTE : ST_WORD;
                end
                ST_WORD: begin
                    if (swt_pkg::is_space(i_ch)) begin
                        n_st = ST_SPACE;
                        if (n_ne || (px && n_sq)) begin
                            res[cnt[0]] = swt_pkg::mk_result(8'h00, 1'b0, 1'b1, 1'b0);
                            cnt  = cnt + 2'd1;
                            n_ne = 1'b0;
                            n_sq = 1'b0;
                        end
                    end else if (hash_on) begin
                        n_ciw = 1'b1;
                        n_st  = ST_COMMENT;
                    end else if (px && swt_pkg::is_quote(i_ch)) begin
                        n_st = (i_ch == swt_pkg::CH_SQUOTE) ? ST_SQUOTE : ST_DQUOTE;
                    end else if (px && (i_ch == swt_pkg::CH_BSLASH)) begin
                        n_esc = ST_WORD;
                        n_st  = ST_ESCAPE;
                    end else if (swt_pkg::is_wordch(i_ch) || swt_pkg::is_quote(i_ch) ||
                                 r_split_ws) begin
                        res[cnt[0]] = swt_pkg::mk_result(i_ch, 1'b1, 1'b0, 1'b0);
                        cnt  = cnt + 2'd1;
                        n_ne = 1'b1;
                    end else begin
                        // close the word, then the punctuation token
                        n_st = ST_SPACE;
                        if (n_ne || (px && n_sq)) begin
                            res[cnt[0]] = swt_pkg::mk_result(8'h00, 1'b0, 1'b1, 1'b0);
                            cnt = cnt + 2'd1;
                        end
                        res[cnt[0]] = swt_pkg::mk_result(i_ch, 1'b1, 1'b1, 1'b0);
                        cnt  = cnt + 2'd1;
                        n_ne = 1'b0;
                        n_sq = 1'b0;
                    end
                end
                ST_COMMENT: begin
                    if (i_ch == swt_pkg::CH_NL) begin
                        if (r_ciw && !px) begin
                            n_st = ST_WORD;
                        end else begin
                            n_st = ST_SPACE;
                            if (r_ciw && (n_ne || (px && n_sq))) begin
                                res[cnt[0]] = swt_pkg::mk_result(8'h00, 1'b0, 1'b1, 1'b0);
                                cnt  = cnt + 2'd1;
                                n_ne = 1'b0;
                                n_sq = 1'b0;
                            end
                        end
                        n_ciw = 1'b0;
                    end
                end
                default: begin
                    n_st = ST_DONE;
                end
            endcase
        end
        // flag the last result of this item
        if (cnt == 2'd1) res[0].last_of_item = 1'b1;
        if (cnt == 2'd2) res[1].last_of_item = 1'b1;
    end

    // Advance the lexer on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_SPACE;
            r_esc <= ST_WORD;
            r_ciw <= 1'b0;
            r_sq  <= 1'b0;
            r_ne  <= 1'b0;
        end else if (accept) begin
            r_st  <= n_st;
            r_esc <= n_esc;
            r_ciw <= n_ciw;
            r_sq  <= n_sq;
            r_ne  <= n_ne;
        end
    end

    // Queue only items that produce results
    assign o_push            = accept && (cnt != 2'd0);
    assign o_push_entry.two  = cnt[1];
    assign o_push_entry.res0 = res[0];
    assign o_push_entry.res1 = res[1];

endmodule

/* rtl/core/swt_queue.sv */
// Short queue of result entries between the lexer and the output stage.
module swt_queue #(
    parameter int P_DEPTH = swt_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  swt_pkg::t_entry i_push_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_avail,
    output swt_pkg::t_entry o_head
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    swt_pkg::t_entry r_mem [P_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_push_entry;
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule

/* rtl/core/swt_back.sv */
// Back end: splits queue entries, drives the output one result a cycle unless stalled.
module swt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_avail,
    input  swt_pkg::t_entry i_head,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [7:0]      o_out_char,
    output logic            o_char_valid,
    output logic            o_token_end,
    output logic            o_text_done,
    output logic            o_last_of_item
);

    logic             r_valid;
    logic             r_sel;
    swt_pkg::t_result r_res;
    logic             can_load;

    assign can_load = !r_valid || !i_stall;
    assign o_pop    = can_load && i_avail && (!i_head.two || r_sel);

    // Load the next result when the output register is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (can_load) begin
            r_valid <= i_avail;
            if (i_avail) r_sel <= !o_pop;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (can_load && i_avail) r_res <= r_sel ? i_head.res1 : i_head.res0;
    end

    assign o_valid        = r_valid;
    assign o_out_char     = r_res.out_char;
    assign o_char_valid   = r_res.char_valid;
    assign o_token_end    = r_res.token_end;
    assign o_text_done    = r_res.text_done;
    assign o_last_of_item = r_res.last_of_item;

endmodule

/* rtl/core/shell_word_tokenizer_core.sv */
// Top level of the shell word tokenizer: lexer front, result queue, output back.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_ch, i_end_of_text
//   result    out        o_valid / i_stall    o_out_char .. o_last_of_item
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle while the queue has room. An item yields zero, one or
// two results; the output register sends one result a cycle while i_stall is low. The
// first result is registered in the queue and then in the output register.
// Reset is synchronous and needs no clearing pass; o_stall rises only when the
// P_QUEUE_DEPTH-entry queue is full, so a stalled output only backs up through the queue.
module shell_word_tokenizer_core #(
    parameter int P_QUEUE_DEPTH = swt_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_ch,
    input  logic                            i_end_of_text,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_out_char,
    output logic                            o_char_valid,
    output logic                            o_token_end,
    output logic                            o_text_done,
    output logic                            o_last_of_item,
    input  logic                            i_cfg_we,
    input  logic [swt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [swt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic            q_full, q_avail, push, pop;
    swt_pkg::t_entry push_entry, head;

    swt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ch         (i_ch),
        .i_end_of_text(i_end_of_text),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_push_entry (push_entry)
    );

    swt_queue #(
        .P_DEPTH(P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_entry(push_entry),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_avail     (q_avail),
        .o_head      (head)
    );

    swt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (q_avail),
        .i_head        (head),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_char    (o_out_char),
        .o_char_valid  (o_char_valid),
        .o_token_end   (o_token_end),
        .o_text_done   (o_text_done),
        .o_last_of_item(o_last_of_item)
    );

endmodule

/* rtl/core/swt_checker.sv */
// Port-level checker of the tokenizer and its bind to the top level.
`include "shell_word_tokenizer_core_assert.svh"

module swt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_char,
    input logic       o_char_valid,
    input logic       o_token_end,
    input logic       o_text_done,
    input logic       o_last_of_item
);

    // end of text is a bare mark and always closes its item
    `SWT_ASSERT_NOW(a_done_bare, o_valid && o_text_done, !o_char_valid && !o_token_end && o_last_of_item, "text_done result carries other fields")

    // nothing follows the end of text
    `SWT_ASSERT_NEXT(a_done_final, o_valid && o_text_done && !i_stall, !o_valid, "result after text_done")

    // a result without a byte shows a zero byte and marks something
    `SWT_ASSERT_NOW(a_empty_result, o_valid && !o_char_valid, o_out_char == 8'h00 && (o_token_end || o_text_done), "empty result")

    // stalled result holds
    `SWT_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_out_char) && $stable(o_last_of_item), "stalled result changed")

endmodule

bind shell_word_tokenizer_core swt_checker u_swt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_out_char    (o_out_char),
    .o_char_valid  (o_char_valid),
    .o_token_end   (o_token_end),
    .o_text_done   (o_text_done),
    .o_last_of_item(o_last_of_item)
);
